// ===== rtl/core/pid_pdc_pkg.sv =====
// Shared types, register indexes and helpers for the position/delta PID controller.
// Used by pid_pdc_step and pid_position_delta_controller; depends on nothing else.

package pid_pdc_pkg;

   localparam int GAIN_W  = 31;   // unsigned Q15.16 gain
   localparam int LIMIT_W = 15;   // integer clamp limit
   localparam int ERR_W   = 17;   // target - measured
   localparam int Q_W     = 32;   // signed Q15.16 integral and drive
   localparam int ACC_W   = 53;   // wide enough for the sum of three products and a Q15.16 term
   localparam int FRAC_W  = 16;
   localparam int SAMPLE_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd5;

   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0] drive_limit;
      logic [LIMIT_W-1:0] integral_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] last_error;
      logic signed [ERR_W-1:0] older_error;
      logic signed [Q_W-1:0]   integral_term;
      logic signed [Q_W-1:0]   drive_value;
   } hist_type;

   // Symmetric clamp of a wide Q.16 value to +/- (lim << 16); the result fits in Q15.16.
   function automatic logic signed [Q_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] x,
                                                       input logic [LIMIT_W-1:0] lim);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      logic signed [ACC_W-1:0] sel;
      hi = $signed({{(ACC_W-LIMIT_W-FRAC_W){1'b0}}, lim, {FRAC_W{1'b0}}});
      lo = -hi;
      if (x > hi) begin
         sel = hi;
      end else if (x < lo) begin
         sel = lo;
      end else begin
         sel = x;
      end
      return sel[Q_W-1:0];
   endfunction

endpackage

// ===== rtl/core/pid_pdc_step.sv =====
// One control step of the position/delta PID controller, purely combinational.
// Depends on pid_pdc_pkg for the configuration and history types and the clamp.

module pid_pdc_step (
   input  pid_pdc_pkg::cfg_type                   cfg,
   input  pid_pdc_pkg::hist_type                  hist,
   input  logic                                   operation,
   input  logic signed [pid_pdc_pkg::SAMPLE_W-1:0] target,
   input  logic signed [pid_pdc_pkg::SAMPLE_W-1:0] measured,
   output pid_pdc_pkg::hist_type                  hist_in,
   output logic signed [pid_pdc_pkg::SAMPLE_W-1:0] drive
);
   import pid_pdc_pkg::*;

   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W:0]     diff1;
   logic signed [ERR_W+1:0]   diff2;
   logic signed [ERR_W+1:0]   mul_p_arg;
   logic signed [ERR_W+1:0]   mul_d_arg;
   logic signed [GAIN_W:0]    gp;
   logic signed [GAIN_W:0]    gi;
   logic signed [GAIN_W:0]    gd;
   logic signed [ACC_W-1:0]   prod_p;
   logic signed [ACC_W-1:0]   prod_i;
   logic signed [ACC_W-1:0]   prod_d;
   logic signed [ACC_W-1:0]   integral_base;
   logic signed [ACC_W-1:0]   integral_sum;
   logic signed [Q_W-1:0]     integral_new;
   logic signed [ACC_W-1:0]   drive_base;
   logic signed [ACC_W-1:0]   extra_i;
   logic signed [ACC_W-1:0]   drive_sum;
   logic signed [Q_W-1:0]     drive_new;

   always_comb begin
      err   = ERR_W'($signed({target[SAMPLE_W-1], target}) -
                     $signed({measured[SAMPLE_W-1], measured}));
      diff1 = $signed({err[ERR_W-1], err}) -
              $signed({hist.last_error[ERR_W-1], hist.last_error});
      // Second difference: e - 2*e1 + e2.
      diff2 = $signed({diff1[ERR_W], diff1}) -
              $signed({{2{hist.last_error[ERR_W-1]}}, hist.last_error}) +
              $signed({{2{hist.older_error[ERR_W-1]}}, hist.older_error});

      // Positional mode works on e and e - e1; incremental on the next difference up.
      if (cfg.mode == MODE_INCREMENTAL) begin
         mul_p_arg = $signed({diff1[ERR_W], diff1});
         mul_d_arg = diff2;
      end else begin
         mul_p_arg = $signed({{2{err[ERR_W-1]}}, err});
         mul_d_arg = $signed({diff1[ERR_W], diff1});
      end

      gp = $signed({1'b0, cfg.gain_p});
      gi = $signed({1'b0, cfg.gain_i});
      gd = $signed({1'b0, cfg.gain_d});

      prod_p = $signed({{(ACC_W-GAIN_W-1){1'b0}}, gp}) *
               $signed({{(ACC_W-ERR_W-2){mul_p_arg[ERR_W+1]}}, mul_p_arg});
      prod_i = $signed({{(ACC_W-GAIN_W-1){1'b0}}, gi}) *
               $signed({{(ACC_W-ERR_W){err[ERR_W-1]}}, err});
      prod_d = $signed({{(ACC_W-GAIN_W-1){1'b0}}, gd}) *
               $signed({{(ACC_W-ERR_W-2){mul_d_arg[ERR_W+1]}}, mul_d_arg});

      if (cfg.mode == MODE_INCREMENTAL) begin
         integral_base = '0;
      end else begin
         integral_base = $signed({{(ACC_W-Q_W){hist.integral_term[Q_W-1]}},
                                  hist.integral_term});
      end
      integral_sum = integral_base + prod_i;
      integral_new = clamp_sym(integral_sum, cfg.integral_limit);

      if (cfg.mode == MODE_INCREMENTAL) begin
         drive_base = $signed({{(ACC_W-Q_W){hist.drive_value[Q_W-1]}}, hist.drive_value});
         extra_i    = prod_i;
      end else begin
         drive_base = $signed({{(ACC_W-Q_W){integral_new[Q_W-1]}}, integral_new});
         extra_i    = '0;
      end
      drive_sum = drive_base + prod_p + extra_i + prod_d;
      drive_new = clamp_sym(drive_sum, cfg.drive_limit);

      if (operation == OP_CLEAR) begin
         hist_in = '0;
         drive   = '0;
      end else begin
         hist_in.last_error    = err;
         hist_in.older_error   = hist.last_error;
         hist_in.integral_term = integral_new;
         hist_in.drive_value   = drive_new;
         // The arithmetic shift by the fraction width is the floor of the Q15.16 drive.
         drive = drive_new[Q_W-1:FRAC_W];
      end
   end

endmodule

// ===== rtl/core/pid_position_delta_controller.sv =====
// Top level of the position/delta PID controller: stream ports, register file,
// input and result registers and controller history. Depends on pid_pdc_pkg and pid_pdc_step.

// Each item is either a control step (tuser low) or a clear of all history (tuser high) and
// gives exactly one drive result. An accepted item lands in the input register, is evaluated
// by a single stage of three gain multipliers, two adders and clamps once the result register
// is empty or being drained, and its result then sits in the result register, where it is
// presented until taken. One item is taken per clock, sustained, while rsp_tready stays high,
// since the history is updated in the same cycle the result is registered; the input register
// also holds one item while a result waits for rsp_tready. Configuration writes take effect
// at once and are meant to be made while the block is idle.

module pid_position_delta_controller (
   input  logic                                    clock,
   input  logic                                    reset,
   // Input items.
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [31:0]                             req_tdata,   // target[15:0], measured[31:16]
   input  logic                                    req_tuser,   // operation
   // Result items.
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [15:0]                             rsp_tdata,   // drive[15:0]
   // Register writes.
   input  logic                                    csr_we,
   input  logic [pid_pdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pid_pdc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pid_pdc_pkg::*;

   cfg_type                     cfg_ff;
   hist_type                    hist_ff;
   hist_type                    hist_in;

   logic                        req_valid_ff;
   logic                        op_ff;
   logic signed [SAMPLE_W-1:0]  target_ff;
   logic signed [SAMPLE_W-1:0]  measured_ff;

   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  drive_ff;
   logic signed [SAMPLE_W-1:0]  drive_in;

   logic                        fire;

   // The held item moves on once the result register is empty or being drained.
   assign fire       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || fire;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

   pid_pdc_step u_step (
      .cfg       (cfg_ff),
      .hist      (hist_ff),
      .operation (op_ff),
      .target    (target_ff),
      .measured  (measured_ff),
      .hist_in   (hist_in),
      .drive     (drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:           cfg_ff.mode           <= csr_wdata[0];
            CSR_GAIN_P:         cfg_ff.gain_p         <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_ff.gain_i         <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_ff.gain_d         <= csr_wdata[GAIN_W-1:0];
            CSR_DRIVE_LIMIT:    cfg_ff.drive_limit    <= csr_wdata[LIMIT_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_ff.integral_limit <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hist_ff      <= '0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            hist_ff      <= hist_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff       <= req_tuser;
         target_ff   <= $signed(req_tdata[SAMPLE_W-1:0]);
         measured_ff <= $signed(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
      end
      if (fire) begin
         drive_ff <= drive_in;
      end
   end

endmodule

// ===== verif/tb_pid_position_delta_controller.sv =====
// Self-checking testbench for the position/delta PID controller: directed and random items,
// random handshake gaps on both streams, per-result comparison against an in-bench predictor.
// Depends on pid_pdc_pkg and pid_position_delta_controller.

module tb_pid_position_delta_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import pid_pdc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [GAIN_W-1:0] ONE_Q16 = 31'h10000;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [31:0]             req_tdata  = '0;   // target[15:0], measured[31:16]
   logic                    req_tuser  = 1'b0; // operation
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [15:0]             rsp_tdata;         // drive[15:0]
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   cfg_type     ctl_cfg  = '0;
   hist_type    ctl_hist = '0;
   logic [15:0] drive_expected[$];
   int          fail_count  = 0;
   int          cycle_count = 0;
   bit          no_idle     = 1'b0;

   pid_position_delta_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_q16(longint x, logic [LIMIT_W-1:0] lim);
      longint bound;
      bound = longint'(lim) <<< FRAC_W;
      if (x > bound) begin
         return bound;
      end
      if (x < -bound) begin
         return -bound;
      end
      return x;
   endfunction

   // Advances the controller history by one item and returns the expected drive.
   function automatic logic [15:0] next_drive(logic op, logic [15:0] tgt, logic [15:0] meas);
      longint e;
      longint e1;
      longint e2;
      longint integ;
      longint drv;
      if (op == OP_CLEAR) begin
         ctl_hist = '0;
         return '0;
      end
      e  = longint'($signed(tgt)) - longint'($signed(meas));
      e1 = longint'($signed(ctl_hist.last_error));
      e2 = longint'($signed(ctl_hist.older_error));
      ctl_hist.older_error = ctl_hist.last_error;
      ctl_hist.last_error  = e[ERR_W-1:0];
      if (ctl_cfg.mode == MODE_POSITIONAL) begin
         integ = clamp_q16(longint'($signed(ctl_hist.integral_term))
                           + longint'(ctl_cfg.gain_i) * e, ctl_cfg.integral_limit);
         ctl_hist.integral_term = integ[Q_W-1:0];
         drv = clamp_q16(longint'(ctl_cfg.gain_p) * e + integ
                         + longint'(ctl_cfg.gain_d) * (e - e1), ctl_cfg.drive_limit);
      end else begin
         // The stored integral is clamped, but the drive increment uses the raw product.
         integ = longint'(ctl_cfg.gain_i) * e;
         drv = clamp_q16(integ, ctl_cfg.integral_limit);
         ctl_hist.integral_term = drv[Q_W-1:0];
         drv = clamp_q16(longint'($signed(ctl_hist.drive_value))
                         + longint'(ctl_cfg.gain_p) * (e - e1) + integ
                         + longint'(ctl_cfg.gain_d) * (e - 2 * e1 + e2), ctl_cfg.drive_limit);
      end
      ctl_hist.drive_value = drv[Q_W-1:0];
      drv = drv >>> FRAC_W;
      return drv[15:0];
   endfunction

   task automatic send_item(logic op, logic [15:0] tgt, logic [15:0] meas);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {meas, tgt};
      do @(posedge clock); while (!req_tready);
      drive_expected.push_back(next_drive(op, tgt, meas));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic mode, logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                            logic [GAIN_W-1:0] kd, logic [LIMIT_W-1:0] dlim,
                            logic [LIMIT_W-1:0] ilim);
      logic [CSR_DATA_W-1:0] value [6];
      int idx;
      value[CSR_MODE]           = CSR_DATA_W'(mode);
      value[CSR_GAIN_P]         = kp;
      value[CSR_GAIN_I]         = ki;
      value[CSR_GAIN_D]         = kd;
      value[CSR_DRIVE_LIMIT]    = CSR_DATA_W'(dlim);
      value[CSR_INTEGRAL_LIMIT] = CSR_DATA_W'(ilim);
      for (idx = 0; idx < 6; idx++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(idx);
         csr_wdata <= value[idx];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      ctl_cfg = '{mode, kp, ki, kd, dlim, ilim};
   endtask

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return GAIN_W'($urandom());
         default: return GAIN_W'($urandom_range(0, 32'h3FFFF));
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] rand_limit();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return LIMIT_W'($urandom());
         default: return LIMIT_W'($urandom_range(0, 2000));
      endcase
   endfunction

   // Half of the samples are small, so that the clamps are not always active.
   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3, 4: return 16'($urandom());
         default: return 16'($signed($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   task automatic test_reset_state();
      // All limits are zero after reset, so every drive is pinned at zero.
      send_item(OP_STEP, 16'sd100, -16'sd100);
      send_item(OP_CLEAR, 16'h7FFF, 16'h8000);
      send_item(OP_STEP, 16'h7FFF, 16'h8000);
      wait_idle();
   endtask

   task automatic test_positional();
      configure(MODE_POSITIONAL, ONE_Q16, ONE_Q16 >> 1, ONE_Q16 >> 2, 15'd1000, 15'd200);
      send_item(OP_STEP, 16'sd10, 16'sd0);
      send_item(OP_STEP, 16'sd10, 16'sd3);
      send_item(OP_STEP, -16'sd5, 16'sd7);
      send_item(OP_STEP, 16'h7FFF, 16'h8000);
      send_item(OP_STEP, 16'h8000, 16'h7FFF);
      send_item(OP_STEP, 16'sd0, 16'sd0);
      send_item(OP_CLEAR, 16'sd55, -16'sd9);
      send_item(OP_STEP, 16'sd1, 16'sd2);
      wait_idle();
   endtask

   task automatic test_incremental();
      configure(MODE_INCREMENTAL, ONE_Q16, ONE_Q16 >> 3, ONE_Q16 >> 1, 15'd3000, 15'd50);
      send_item(OP_STEP, 16'sd20, 16'sd0);
      send_item(OP_STEP, 16'sd20, 16'sd5);
      send_item(OP_STEP, 16'sd0, 16'sd30);
      send_item(OP_STEP, 16'h8000, 16'h7FFF);
      send_item(OP_CLEAR, 16'sd1, 16'sd1);
      send_item(OP_STEP, 16'sd7, 16'sd7);
      send_item(OP_STEP, -16'sd3, 16'sd0);
      wait_idle();
   endtask

   task automatic test_mode_switch();
      // No clear here: positional mode picks up the integral and errors left behind.
      configure(MODE_POSITIONAL, ONE_Q16, ONE_Q16 >> 3, ONE_Q16 >> 1, 15'd3000, 15'd50);
      send_item(OP_STEP, -16'sd40, 16'sd0);
      send_item(OP_STEP, 16'sd12, 16'sd4);
      wait_idle();
   endtask

   task automatic test_extreme_settings();
      configure(MODE_POSITIONAL, '1, '1, '1, '1, '1);
      send_item(OP_STEP, 16'h7FFF, 16'h8000);
      send_item(OP_STEP, 16'h8000, 16'h7FFF);
      wait_idle();
      configure(MODE_INCREMENTAL, '1, '1, '1, '0, '0);
      send_item(OP_STEP, 16'sd1, 16'sd0);
      wait_idle();
      // Tiny gains give a small negative fraction, which must floor to -1.
      configure(MODE_INCREMENTAL, 31'd1, 31'd1, 31'd1, '1, '1);
      send_item(OP_CLEAR, 16'sd0, 16'sd0);
      send_item(OP_STEP, -16'sd1, 16'sd0);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int phase;
      int n;
      logic op;
      for (phase = 0; phase < 10; phase++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         configure($urandom_range(0, 1) ? MODE_INCREMENTAL : MODE_POSITIONAL,
                   rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
         for (n = 0; n < 200; n++) begin
            op = ($urandom_range(0, 29) == 0) ? OP_CLEAR : OP_STEP;
            send_item(op, rand_sample(), rand_sample());
         end
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   // Result side: random stalls between items.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_expected.size() == 0) begin
            $display("%0t: unexpected drive item %0d with nothing pending",
                     $time, $signed(rsp_tdata));
            fail_count++;
         end else begin
            want = drive_expected.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: drive mismatch: expected %0d, actual %0d",
                        $time, $signed(want), $signed(rsp_tdata));
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_positional();
      test_incremental();
      test_mode_switch();
      test_extreme_settings();
      test_random_phases();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
